[hw/rtl/deformation_gradient_strain_update_macros.svh]
// Assertion macros for the deformation gradient strain update block.
// Relies on clk and rst_n in the scope where each macro is used.
`ifndef DEFORMATION_GRADIENT_STRAIN_UPDATE_MACROS_SVH
`define DEFORMATION_GRADIENT_STRAIN_UPDATE_MACROS_SVH
`ifndef SYNTHESIS
`define DGSU_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dgsu: same-cycle check failed");
`define DGSU_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dgsu: next-cycle check failed");
`else
`define DGSU_ASSERT_SAME(label, ante, cons)
`define DGSU_ASSERT_NEXT(label, ante, cons)
`endif
`endif

[hw/rtl/dgsu_pkg.sv]
// Shared constants, types and helpers for the deformation gradient strain update.
// No dependencies.
`timescale 1ns / 1ps
package dgsu_pkg;

  localparam int WORD_W         = 32;
  localparam int PT_W           = 6;
  localparam int TS_W           = 31;
  localparam int ROW_W          = 2;
  localparam int ELEMS          = 9;
  localparam int ELEM_W         = 4;
  localparam int NUM_POINTS_DEF = 64;
  localparam int FRAC_BITS_DEF  = 24;

  localparam logic [TS_W-1:0]  TS_RESET = TS_W'(16777);
  localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(2);

  typedef struct packed {
    logic                     valid;
    logic                     first;
    logic signed [WORD_W-1:0] addend;
  } dgsu_mac_ctl_t;

  function automatic logic [ELEM_W-1:0] elem_idx(input logic [1:0] r, input logic [1:0] c);
    elem_idx = ELEM_W'(r) * ELEM_W'(3) + ELEM_W'(c);
  endfunction

endpackage

[hw/rtl/dgsu_channels.sv]
// Handshake channels for the deformation gradient strain update.
// Depends on dgsu_pkg.
`timescale 1ns / 1ps
interface dgsu_in_if import dgsu_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [PT_W-1:0]          point_index;
  logic signed [WORD_W-1:0] grad_00;
  logic signed [WORD_W-1:0] grad_01;
  logic signed [WORD_W-1:0] grad_02;
  logic signed [WORD_W-1:0] grad_10;
  logic signed [WORD_W-1:0] grad_11;
  logic signed [WORD_W-1:0] grad_12;
  logic signed [WORD_W-1:0] grad_20;
  logic signed [WORD_W-1:0] grad_21;
  logic signed [WORD_W-1:0] grad_22;

  modport source (output valid, point_index, grad_00, grad_01, grad_02, grad_10, grad_11,
                  grad_12, grad_20, grad_21, grad_22, input ready);
  modport sink (input valid, point_index, grad_00, grad_01, grad_02, grad_10, grad_11,
                grad_12, grad_20, grad_21, grad_22, output ready);
endinterface

interface dgsu_out_if import dgsu_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [PT_W-1:0]          out_point;
  logic [ROW_W-1:0]         row_number;
  logic signed [WORD_W-1:0] defgrad_c0;
  logic signed [WORD_W-1:0] defgrad_c1;
  logic signed [WORD_W-1:0] defgrad_c2;
  logic signed [WORD_W-1:0] strain_c0;
  logic signed [WORD_W-1:0] strain_c1;
  logic signed [WORD_W-1:0] strain_c2;
  logic                     last_row;

  modport source (output valid, out_point, row_number, defgrad_c0, defgrad_c1, defgrad_c2,
                  strain_c0, strain_c1, strain_c2, last_row, input ready);
  modport sink (input valid, out_point, row_number, defgrad_c0, defgrad_c1, defgrad_c2,
                strain_c0, strain_c1, strain_c2, last_row, output ready);
endinterface

[hw/rtl/dgsu_mac.sv]
// Shared multiply, floor-shift and accumulate unit with saturated readout.
// Depends on dgsu_pkg.
`timescale 1ns / 1ps
module dgsu_mac import dgsu_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  dgsu_mac_ctl_t            ctl,
  input  logic signed [WORD_W-1:0] op_a,
  input  logic signed [WORD_W-1:0] op_b,
  output logic signed [WORD_W-1:0] sat_full,
  output logic signed [WORD_W-1:0] sat_half
);

  localparam int ACC_W = 2 * WORD_W - FRAC_BITS + 3;
  localparam logic signed [WORD_W-1:0] WMAX = {1'b0, {(WORD_W-1){1'b1}}};
  localparam logic signed [WORD_W-1:0] WMIN = {1'b1, {(WORD_W-1){1'b0}}};

  dgsu_mac_ctl_t              ctl_r;
  logic signed [2*WORD_W-1:0] prod_r;
  logic signed [ACC_W-1:0]    acc_r;
  logic signed [ACC_W-1:0]    acc_nxt;
  logic signed [ACC_W-1:0]    shifted;
  logic signed [ACC_W-1:0]    half;
  logic                       full_fits;
  logic                       half_fits;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r <= ctl;
    end
    if (ctl.valid) begin
      prod_r <= op_a * op_b;
    end
    if (ctl_r.valid) begin
      acc_r <= acc_nxt;
    end
  end

  always_comb begin
    shifted = ACC_W'(prod_r >>> FRAC_BITS);
    acc_nxt = ctl_r.first ? (ACC_W'(ctl_r.addend) + shifted) : (acc_r + shifted);
    half    = acc_r >>> 1;
    full_fits = (&acc_r[ACC_W-1:WORD_W-1]) || !(|acc_r[ACC_W-1:WORD_W-1]);
    half_fits = (&half[ACC_W-1:WORD_W-1]) || !(|half[ACC_W-1:WORD_W-1]);
    sat_full = full_fits ? acc_r[WORD_W-1:0] : (acc_r[ACC_W-1] ? WMIN : WMAX);
    sat_half = half_fits ? half[WORD_W-1:0] : (half[ACC_W-1] ? WMIN : WMAX);
  end

endmodule

[hw/rtl/deformation_gradient_strain_update.sv]
// Flow: an accepted input passes through ST_LOAD, ST_FDOT and ST_STRAIN, then ST_EMIT sends one
// result row per cycle while out_chan.ready is high. A new item is taken only in ST_IDLE; the
// single shared multiplier does all products (36 for F, 27 for E, each with its accumulate wait).
// Reset: synchronous active-low; a clearing pass writes identity into every point,
// during which no input transaction is taken.
// Depends on dgsu_pkg, dgsu_channels, dgsu_mac and the assertion macro header.
`timescale 1ns / 1ps
`include "deformation_gradient_strain_update_macros.svh"
module deformation_gradient_strain_update import dgsu_pkg::*; #(
  parameter int NUM_POINTS = NUM_POINTS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cfg_wr_en,
  input  logic [TS_W-1:0] cfg_wr_data,
  dgsu_in_if.sink         in_chan,
  dgsu_out_if.source      out_chan
);

  localparam int DEPTH  = NUM_POINTS * ELEMS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);
  localparam logic signed [WORD_W-1:0] ONE_VAL = WORD_W'(1) << FRAC_BITS;
  localparam logic signed [WORD_W-1:0] NEG_ONE = -ONE_VAL;
  localparam logic [ELEM_W-1:0] LOAD_DONE   = ELEM_W'(ELEMS);
  localparam logic [ELEM_W-1:0] LAST_ELEM   = ELEM_W'(ELEMS - 1);
  localparam logic [2:0]        STEP_WAIT   = 3'd3;
  localparam logic [2:0]        STEP_DT     = 3'd4;
  localparam logic [2:0]        FDOT_LAST   = 3'd6;
  localparam logic [2:0]        STRAIN_LAST = 3'd4;
  localparam logic [1:0]        LAST_IDX    = 2'd2;

  typedef enum logic [5:0] {
    ST_CLEAR  = 6'b000001,
    ST_IDLE   = 6'b000010,
    ST_LOAD   = 6'b000100,
    ST_FDOT   = 6'b001000,
    ST_STRAIN = 6'b010000,
    ST_EMIT   = 6'b100000
  } state_t;

  state_t                   state_r, state_nxt;
  logic [ELEM_W-1:0]        cnt_r, cnt_nxt;
  logic [ADDR_W-1:0]        clr_addr_r, clr_addr_nxt;
  logic [1:0]               ri_r, ri_nxt;
  logic [1:0]               cj_r, cj_nxt;
  logic [2:0]               step_r, step_nxt;
  logic [ROW_W-1:0]         row_r, row_nxt;
  logic [TS_W-1:0]          time_step_r;
  logic [PT_W-1:0]          point_r;
  logic [ADDR_W-1:0]        base_r;
  logic signed [WORD_W-1:0] lg_r     [ELEMS];
  logic signed [WORD_W-1:0] fo_r     [ELEMS];
  logic signed [WORD_W-1:0] fn_r     [ELEMS];
  logic signed [WORD_W-1:0] fnt_r    [ELEMS];
  logic signed [WORD_W-1:0] strain_r [ELEMS];
  logic signed [WORD_W-1:0] store_r  [DEPTH];
  logic signed [WORD_W-1:0] rd_data_r;

  logic                     in_fire, out_fire, pt_ok;
  logic                     fdot_done, strain_done, cell_last;
  logic                     rd_en, store_we, clr_diag;
  logic [ADDR_W-1:0]        rd_addr, store_addr;
  logic signed [WORD_W-1:0] store_wdata;
  logic [1:0]               k_idx;
  logic [ELEM_W-1:0]        fo_sel, cur_idx;
  logic signed [WORD_W-1:0] fo_word;
  dgsu_mac_ctl_t            mac_ctl;
  logic signed [WORD_W-1:0] mac_a, mac_b, mac_full, mac_half;

  assign in_fire  = in_chan.valid && in_chan.ready;
  assign out_fire = out_chan.valid && out_chan.ready;
  assign pt_ok    = 32'(in_chan.point_index) < 32'(NUM_POINTS);
  assign in_chan.ready = (state_r == ST_IDLE);

  assign k_idx       = step_r[1:0];
  assign cur_idx     = elem_idx(ri_r, cj_r);
  assign fdot_done   = (state_r == ST_FDOT) && (step_r == FDOT_LAST);
  assign strain_done = (state_r == ST_STRAIN) && (step_r == STRAIN_LAST);
  assign cell_last   = (ri_r == LAST_IDX) && (cj_r == LAST_IDX);
  assign rd_en       = (state_r == ST_LOAD) && (cnt_r != LOAD_DONE);
  assign rd_addr     = base_r + ADDR_W'(cnt_r);
  assign clr_diag    = (cnt_r == elem_idx(2'd0, 2'd0)) || (cnt_r == elem_idx(2'd1, 2'd1)) ||
                       (cnt_r == elem_idx(2'd2, 2'd2));

  // sequencer
  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    clr_addr_nxt = clr_addr_r;
    ri_nxt       = ri_r;
    cj_nxt       = cj_r;
    step_nxt     = step_r;
    row_nxt      = row_r;
    case (state_r)
      ST_CLEAR: begin
        clr_addr_nxt = clr_addr_r + ADDR_W'(1);
        cnt_nxt      = (cnt_r == LAST_ELEM) ? '0 : cnt_r + ELEM_W'(1);
        if (clr_addr_r == LAST_ADDR) begin
          state_nxt = ST_IDLE;
          cnt_nxt   = '0;
        end
      end
      ST_IDLE: begin
        if (in_fire && pt_ok) begin
          state_nxt = ST_LOAD;
          cnt_nxt   = '0;
        end
      end
      ST_LOAD: begin
        cnt_nxt = cnt_r + ELEM_W'(1);
        if (cnt_r == LOAD_DONE) begin
          state_nxt = ST_FDOT;
          step_nxt  = '0;
          ri_nxt    = '0;
          cj_nxt    = '0;
        end
      end
      ST_FDOT, ST_STRAIN: begin
        step_nxt = step_r + 3'd1;
        if (fdot_done || strain_done) begin
          step_nxt = '0;
          cj_nxt   = (cj_r == LAST_IDX) ? 2'd0 : cj_r + 2'd1;
          ri_nxt   = (cj_r == LAST_IDX) ? ri_r + 2'd1 : ri_r;
          if (cell_last) begin
            ri_nxt    = '0;
            state_nxt = fdot_done ? ST_STRAIN : ST_EMIT;
            row_nxt   = '0;
          end
        end
      end
      ST_EMIT: begin
        if (out_fire) begin
          row_nxt = row_r + ROW_W'(1);
          if (row_r == LAST_ROW) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // operand selection for the shared unit
  always_comb begin
    fo_sel  = (step_r == STEP_DT) ? cur_idx : elem_idx(k_idx, cj_r);
    fo_word = fo_r[fo_sel];
    mac_ctl = '0;
    mac_a   = '0;
    mac_b   = '0;
    if (state_r == ST_FDOT) begin
      if (step_r < STEP_WAIT) begin
        mac_ctl.valid = 1'b1;
        mac_ctl.first = (step_r == 3'd0);
        mac_a         = lg_r[elem_idx(ri_r, k_idx)];
        mac_b         = fo_word;
      end else if (step_r == STEP_DT) begin
        mac_ctl.valid  = 1'b1;
        mac_ctl.first  = 1'b1;
        mac_ctl.addend = fo_word;
        mac_a          = $signed({1'b0, time_step_r});
        mac_b          = mac_full;
      end
    end else if ((state_r == ST_STRAIN) && (step_r < STEP_WAIT)) begin
      mac_ctl.valid  = 1'b1;
      mac_ctl.first  = (step_r == 3'd0);
      mac_ctl.addend = (ri_r == cj_r) ? NEG_ONE : '0;
      mac_a          = fn_r[elem_idx(k_idx, ri_r)];
      mac_b          = fnt_r[elem_idx(k_idx, cj_r)];
    end
  end

  always_comb begin
    store_we    = (state_r == ST_CLEAR) || fdot_done;
    store_addr  = (state_r == ST_CLEAR) ? clr_addr_r : base_r + ADDR_W'(cur_idx);
    store_wdata = (state_r == ST_CLEAR) ? (clr_diag ? ONE_VAL : '0) : mac_full;
  end

  dgsu_mac #(
    .FRAC_BITS (FRAC_BITS)
  ) u_mac (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (mac_ctl),
    .op_a     (mac_a),
    .op_b     (mac_b),
    .sat_full (mac_full),
    .sat_half (mac_half)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      cnt_r       <= '0;
      clr_addr_r  <= '0;
      ri_r        <= '0;
      cj_r        <= '0;
      step_r      <= '0;
      row_r       <= '0;
      time_step_r <= TS_RESET;
    end else begin
      state_r    <= state_nxt;
      cnt_r      <= cnt_nxt;
      clr_addr_r <= clr_addr_nxt;
      ri_r       <= ri_nxt;
      cj_r       <= cj_nxt;
      step_r     <= step_nxt;
      row_r      <= row_nxt;
      if (cfg_wr_en) begin
        time_step_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (store_we) begin
      store_r[store_addr] <= store_wdata;
    end
    if (rd_en) begin
      rd_data_r <= store_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      point_r  <= in_chan.point_index;
      base_r   <= ADDR_W'(int'(in_chan.point_index) * ELEMS);
      lg_r[0]  <= in_chan.grad_00;
      lg_r[1]  <= in_chan.grad_01;
      lg_r[2]  <= in_chan.grad_02;
      lg_r[3]  <= in_chan.grad_10;
      lg_r[4]  <= in_chan.grad_11;
      lg_r[5]  <= in_chan.grad_12;
      lg_r[6]  <= in_chan.grad_20;
      lg_r[7]  <= in_chan.grad_21;
      lg_r[8]  <= in_chan.grad_22;
    end
    if ((state_r == ST_LOAD) && (cnt_r != '0)) begin
      fo_r[cnt_r - ELEM_W'(1)] <= rd_data_r;
    end
    if (fdot_done) begin
      fn_r[cur_idx]  <= mac_full;
      fnt_r[cur_idx] <= mac_full;
    end else if (out_fire) begin
      // advance the next row into the output taps
      for (int e = 0; e < ELEMS - 3; e++) begin
        fn_r[e] <= fn_r[e + 3];
      end
    end
    if (strain_done) begin
      strain_r[cur_idx] <= mac_half;
    end else if (out_fire) begin
      for (int e = 0; e < ELEMS - 3; e++) begin
        strain_r[e] <= strain_r[e + 3];
      end
    end
  end

  assign out_chan.valid      = (state_r == ST_EMIT);
  assign out_chan.out_point  = point_r;
  assign out_chan.row_number = row_r;
  assign out_chan.defgrad_c0 = fn_r[0];
  assign out_chan.defgrad_c1 = fn_r[1];
  assign out_chan.defgrad_c2 = fn_r[2];
  assign out_chan.strain_c0  = strain_r[0];
  assign out_chan.strain_c1  = strain_r[1];
  assign out_chan.strain_c2  = strain_r[2];
  assign out_chan.last_row   = (row_r == LAST_ROW);

  `DGSU_ASSERT_SAME(a_one_item_at_a_time, in_chan.ready, !out_chan.valid)
  `DGSU_ASSERT_NEXT(a_ready_after_last_row, out_fire && out_chan.last_row, in_chan.ready)
  `DGSU_ASSERT_NEXT(a_drop_bad_point, in_fire && !pt_ok, in_chan.ready)
  `DGSU_ASSERT_SAME(a_no_store_write_when_ready, store_we, !in_chan.ready)

endmodule
